FILE: design/fbsc_pkg.sv
// Shared types and constants for the frame buffer swap chain tracker.
`timescale 1ns / 1ps
`default_nettype none

package fbsc_pkg;

   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned STAMP_W   = 32;
   localparam int unsigned CFG_W     = 4;
   localparam int unsigned OUT_IDX_W = 3;

   localparam logic [STAMP_W-1:0] STAMP_NONE = '1;

   typedef enum logic [1:0] {
      ACT_SET_FRONT = 2'd0,
      ACT_SET_BACK  = 2'd1,
      ACT_SWAP      = 2'd2,
      ACT_RESTART   = 2'd3
   } action_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  origin;
      logic [ADDR_W-1:0]  image;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic      en;
      logic      origin_en;
      logic      image_en;
      logic      stamp_en;
      entry_type data;
   } ram_wr_type;

endpackage

`default_nettype wire

FILE: design/frame_buffer_swap_chain_tracker.sv
// Top level of the frame buffer swap chain tracker: sequencer, flags and result register.
`timescale 1ns / 1ps
`default_nettype none

// A set-front or set-back item scans the table one entry a cycle through the entry
// memory, over at most N entries where N is the active buffer count, and gives a single
// registered result. A swap scans likewise unless its origin is zero, then gives one
// result per entry walked from the old front, or a single one. Throughput: one item at
// a time; the next item is taken once the last result is loaded into the output register.
// Reset (synchronous, active high) and restart empty the table at once through per-entry
// live bits, so there is no clearing pass.
module frame_buffer_swap_chain_tracker #(
   parameter int unsigned MAX_ENTRIES  = 8,
   parameter int unsigned MATCH_WINDOW = 1024
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbsc_pkg::CFG_W-1:0]        csr_buffer_count,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  fbsc_pkg::action_type              req_action,
   input  logic [fbsc_pkg::ADDR_W-1:0]       req_address,
   input  logic [fbsc_pkg::STAMP_W-1:0]      req_dlist_count,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fbsc_pkg::OUT_IDX_W-1:0]    rsp_front_index,
   output logic [fbsc_pkg::OUT_IDX_W-1:0]    rsp_back_index,
   output logic                              rsp_frame_valid,
   output logic [fbsc_pkg::OUT_IDX_W-1:0]    rsp_frame_index,
   output logic                              rsp_skip_frame,
   output logic                              rsp_last
);
   import fbsc_pkg::*;

   // Index width for the table, the largest usable chain and a count wide enough for it.
   localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
   localparam int unsigned N_HI   = (MAX_ENTRIES < 8) ? MAX_ENTRIES : 8;
   localparam int unsigned CNT_W  = $clog2(N_HI + 1);
   localparam logic [ADDR_W-1:0] WINDOW = ADDR_W'(MATCH_WINDOW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWAP,
      ST_WALK,
      ST_SINGLE
   } state_type;

   // Which search the scan performs: before or after the warm-up fill, front or back.
   typedef enum logic [1:0] {
      MODE_FRONT_WARM,
      MODE_FRONT_RUN,
      MODE_BACK_WARM,
      MODE_BACK_RUN
   } mode_type;

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   state_type               state_ff,      state_in;
   mode_type                mode_ff,       mode_in;
   action_type              action_ff,     action_in;
   logic [ADDR_W-1:0]       addr_ff,       addr_in;
   logic [STAMP_W-1:0]      stamp_ff,      stamp_in;
   logic [CFG_W-1:0]        buf_count_ff,  buf_count_in;
   logic [CNT_W-1:0]        active_n_ff,   active_n_in;
   logic [IDX_W-1:0]        front_ptr_ff,  front_ptr_in;
   logic [IDX_W-1:0]        back_ptr_ff,   back_ptr_in;
   logic [IDX_W-1:0]        prev_ff,       prev_in;
   logic [IDX_W-1:0]        walk_ff,       walk_in;
   logic [CNT_W-1:0]        chk_idx_ff,    chk_idx_in;
   logic [STAMP_W-1:0]      min_stamp_ff,  min_stamp_in;
   logic [IDX_W-1:0]        min_idx_ff,    min_idx_in;
   logic                    front_done_ff, front_done_in;
   logic                    back_done_ff,  back_done_in;
   logic [MAX_ENTRIES-1:0]  live_ff,       live_in;
   logic [MAX_ENTRIES-1:0]  valid_ff,      valid_in;
   logic [MAX_ENTRIES-1:0]  is_front_ff,   is_front_in;
   logic                    rd_live_ff;

   logic                    rsp_valid_ff,       rsp_valid_in;
   logic [OUT_IDX_W-1:0]    rsp_front_index_ff, rsp_front_index_in;
   logic [OUT_IDX_W-1:0]    rsp_back_index_ff,  rsp_back_index_in;
   logic                    rsp_frame_valid_ff, rsp_frame_valid_in;
   logic [OUT_IDX_W-1:0]    rsp_frame_index_ff, rsp_frame_index_in;
   logic                    rsp_skip_frame_ff,  rsp_skip_frame_in;
   logic                    rsp_last_ff,        rsp_last_in;

   // ---------------------------------------------------------------------------------
   // Combinational signals
   // ---------------------------------------------------------------------------------
   ram_wr_type              ram_wr;
   logic [IDX_W-1:0]        ram_wr_idx;
   logic [IDX_W-1:0]        ram_rd_idx;
   entry_type               ram_rd_data;

   entry_type               ent;
   logic [IDX_W-1:0]        chk_idx;
   logic [CNT_W-1:0]        chk_nxt;
   logic                    at_end;
   logic [ADDR_W-1:0]       diff_ac;
   logic [ADDR_W-1:0]       diff_ca;
   logic [ADDR_W-1:0]       diff_ao;
   logic                    near_front;
   logic                    near_back;
   logic                    take_min;
   logic [STAMP_W-1:0]      min_stamp_nx;
   logic [IDX_W-1:0]        min_idx_nx;
   logic                    scan_done;
   logic                    out_free;
   logic [IDX_W-1:0]        walk_nxt;
   logic [IDX_W-1:0]        front_nxt;

   // Clamp the configured count into the range the table supports.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] c);
      logic [CNT_W-1:0] r;
      if (c < CFG_W'(2)) begin
         r = CNT_W'(2);
      end else if (c > CFG_W'(N_HI)) begin
         r = CNT_W'(N_HI);
      end else begin
         r = CNT_W'(c);
      end
      return r;
   endfunction

   // Step an index round the chain of n entries.
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] s;
      s = CNT_W'(x) + CNT_W'(1);
      if (s == n) begin
         s = '0;
      end
      return s[IDX_W-1:0];
   endfunction

   // ---------------------------------------------------------------------------------
   // Entry memory: origin, colour image and age stamp of every entry
   // ---------------------------------------------------------------------------------
   fbsc_entry_ram #(
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .wr_idx  (ram_wr_idx),
      .rd_idx  (ram_rd_idx),
      .rd_data (ram_rd_data)
   );

   // An entry that has not been written since reset or restart reads as all zeros.
   assign ent = rd_live_ff ? ram_rd_data : '0;

   // The scan is pipelined: the entry being checked was read in the previous cycle, and
   // the read of the following entry is issued now.
   assign chk_idx = chk_idx_ff[IDX_W-1:0];
   assign chk_nxt = chk_idx_ff + CNT_W'(1);
   assign at_end  = (chk_nxt == active_n_ff);

   // Set-front accepts a colour image on either side of the origin within the window;
   // an exact match has a distance of zero and so also counts.
   assign diff_ac    = addr_ff - ent.image;
   assign diff_ca    = ent.image - addr_ff;
   assign near_front = (addr_ff >= ent.image) ? (diff_ac < WINDOW) : (diff_ca < WINDOW);

   // During the back warm-up the colour image must lie at or above the origin.
   assign diff_ao   = addr_ff - ent.origin;
   assign near_back = (ent.origin <= addr_ff) && (diff_ao < WINDOW);

   // Running minimum of the age stamps for eviction; ties keep the lower index. The back
   // search skips front-marked entries, but with no stamp below all ones entry 0 is taken.
   assign take_min = !((mode_ff == MODE_BACK_RUN) && is_front_ff[chk_idx])
                     && (ent.stamp < min_stamp_ff);
   assign min_stamp_nx = take_min ? ent.stamp : min_stamp_ff;
   assign min_idx_nx   = take_min ? chk_idx   : min_idx_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign walk_nxt  = wrap_inc(walk_ff, active_n_ff);
   assign front_nxt = wrap_inc(front_ptr_ff, active_n_ff);

   // ---------------------------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      action_in     = action_ff;
      addr_in       = addr_ff;
      stamp_in      = stamp_ff;
      buf_count_in  = buf_count_ff;
      active_n_in   = active_n_ff;
      front_ptr_in  = front_ptr_ff;
      back_ptr_in   = back_ptr_ff;
      prev_in       = prev_ff;
      walk_in       = walk_ff;
      chk_idx_in    = chk_idx_ff;
      min_stamp_in  = min_stamp_ff;
      min_idx_in    = min_idx_ff;
      front_done_in = front_done_ff;
      back_done_in  = back_done_ff;
      live_in       = live_ff;
      valid_in      = valid_ff;
      is_front_in   = is_front_ff;

      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_front_index_in = rsp_front_index_ff;
      rsp_back_index_in  = rsp_back_index_ff;
      rsp_frame_valid_in = rsp_frame_valid_ff;
      rsp_frame_index_in = rsp_frame_index_ff;
      rsp_skip_frame_in  = rsp_skip_frame_ff;
      rsp_last_in        = rsp_last_ff;

      ram_wr     = '0;
      ram_wr_idx = chk_idx;
      ram_rd_idx = '0;
      scan_done  = 1'b0;

      if (csr_valid) begin
         buf_count_in = csr_buffer_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Entry 0 is read while waiting, ready for the first scan step.
            if (req_valid) begin
               action_in    = req_action;
               addr_in      = req_address;
               stamp_in     = req_dlist_count;
               prev_in      = front_ptr_ff;
               chk_idx_in   = '0;
               min_stamp_in = STAMP_NONE;
               min_idx_in   = '0;
               mode_in      = front_done_ff ? MODE_FRONT_RUN : MODE_FRONT_WARM;
               unique case (req_action)
                  ACT_SET_FRONT: begin
                     state_in = ST_SCAN;
                  end
                  ACT_SET_BACK: begin
                     mode_in  = back_done_ff ? MODE_BACK_RUN : MODE_BACK_WARM;
                     state_in = ST_SCAN;
                  end
                  ACT_SWAP: begin
                     // A zero origin leaves the front entry as it is.
                     state_in = (req_address != '0) ? ST_SCAN : ST_SWAP;
                  end
                  ACT_RESTART: begin
                     live_in       = '0;
                     valid_in      = '0;
                     is_front_in   = MAX_ENTRIES'(1);
                     front_ptr_in  = '0;
                     back_ptr_in   = IDX_W'(1);
                     front_done_in = 1'b0;
                     back_done_in  = 1'b0;
                     active_n_in   = clamp_count(buf_count_ff);
                     state_in      = ST_SINGLE;
                  end
                  default: begin
                     state_in = ST_SINGLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            ram_rd_idx   = chk_nxt[IDX_W-1:0];
            chk_idx_in   = chk_nxt;
            min_stamp_in = min_stamp_nx;
            min_idx_in   = min_idx_nx;
            unique case (mode_ff)
               MODE_FRONT_WARM: begin
                  if (ent.origin == '0) begin
                     ram_wr.en        = 1'b1;
                     ram_wr.origin_en = 1'b1;
                     if (chk_idx_ff != '0) begin
                        front_done_in = 1'b1;
                     end
                     scan_done = 1'b1;
                  end else if (ent.origin == addr_ff) begin
                     scan_done = 1'b1;
                  end else if (at_end) begin
                     front_done_in = 1'b1;
                     scan_done     = 1'b1;
                  end
               end
               MODE_FRONT_RUN: begin
                  if (!valid_ff[chk_idx] || near_front) begin
                     ram_wr.en        = 1'b1;
                     ram_wr.origin_en = 1'b1;
                     front_ptr_in     = chk_idx;
                     scan_done        = 1'b1;
                  end else if (at_end) begin
                     ram_wr.en        = 1'b1;
                     ram_wr.origin_en = 1'b1;
                     ram_wr_idx       = min_idx_nx;
                     front_ptr_in     = min_idx_nx;
                     scan_done        = 1'b1;
                  end
               end
               MODE_BACK_WARM: begin
                  if (ent.origin == '0) begin
                     ram_wr.en       = 1'b1;
                     ram_wr.image_en = 1'b1;
                     ram_wr.stamp_en = 1'b1;
                     valid_in[chk_idx] = 1'b1;
                     back_ptr_in     = chk_idx;
                     if (chk_idx_ff != '0) begin
                        back_done_in = 1'b1;
                     end
                     scan_done = 1'b1;
                  end else if (near_back) begin
                     // Only an entry without a colour image yet takes this one.
                     if (ent.image == '0) begin
                        ram_wr.en         = 1'b1;
                        ram_wr.image_en   = 1'b1;
                        ram_wr.stamp_en   = 1'b1;
                        valid_in[chk_idx] = 1'b1;
                     end
                     back_ptr_in = chk_idx;
                     scan_done   = 1'b1;
                  end else if (at_end) begin
                     back_done_in = 1'b1;
                     scan_done    = 1'b1;
                  end
               end
               MODE_BACK_RUN: begin
                  if (!valid_ff[chk_idx]) begin
                     ram_wr.en         = 1'b1;
                     ram_wr.image_en   = 1'b1;
                     ram_wr.stamp_en   = 1'b1;
                     valid_in[chk_idx] = 1'b1;
                     back_ptr_in       = chk_idx;
                     scan_done         = 1'b1;
                  end else if (ent.image == addr_ff) begin
                     ram_wr.en       = 1'b1;
                     ram_wr.stamp_en = 1'b1;
                     back_ptr_in     = chk_idx;
                     scan_done       = 1'b1;
                  end else if (at_end) begin
                     ram_wr.en            = 1'b1;
                     ram_wr.image_en      = 1'b1;
                     ram_wr.stamp_en      = 1'b1;
                     ram_wr_idx           = min_idx_nx;
                     valid_in[min_idx_nx] = 1'b1;
                     back_ptr_in          = min_idx_nx;
                     scan_done            = 1'b1;
                  end
               end
               default: begin
                  scan_done = 1'b1;
               end
            endcase
            if (scan_done) begin
               state_in = (action_ff == ACT_SWAP) ? ST_SWAP : ST_SINGLE;
            end
         end

         ST_SWAP: begin
            // A front entry that already carries the front mark ends the swap here.
            state_in = ST_SINGLE;
            if (!is_front_ff[front_ptr_ff]) begin
               is_front_in[prev_ff]      = 1'b0;
               is_front_in[front_ptr_ff] = 1'b1;
               back_ptr_in               = front_nxt;
               walk_in                   = prev_ff;
               if (prev_ff != front_ptr_ff) begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            // One result for each entry passed; all but the new front are skipped.
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_front_index_in = OUT_IDX_W'(front_ptr_ff);
               rsp_back_index_in  = OUT_IDX_W'(back_ptr_ff);
               rsp_frame_valid_in = 1'b1;
               rsp_frame_index_in = OUT_IDX_W'(walk_nxt);
               rsp_skip_frame_in  = (walk_nxt != front_ptr_ff);
               rsp_last_in        = (walk_nxt == front_ptr_ff);
               walk_in            = walk_nxt;
               if (walk_nxt == front_ptr_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_front_index_in = OUT_IDX_W'(front_ptr_ff);
               rsp_back_index_in  = OUT_IDX_W'(back_ptr_ff);
               rsp_frame_valid_in = 1'b0;
               rsp_frame_index_in = '0;
               rsp_skip_frame_in  = 1'b0;
               rsp_last_in        = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write data is always the item's address or stamp. An entry that is not live yet
      // is written whole, so its other fields take their cleared value of zero.
      if (ram_wr.en) begin
         ram_wr.data.origin = ram_wr.origin_en ? addr_ff  : '0;
         ram_wr.data.image  = ram_wr.image_en  ? addr_ff  : '0;
         ram_wr.data.stamp  = ram_wr.stamp_en  ? stamp_ff : '0;
         if (!live_ff[ram_wr_idx]) begin
            ram_wr.origin_en = 1'b1;
            ram_wr.image_en  = 1'b1;
            ram_wr.stamp_en  = 1'b1;
         end
         live_in[ram_wr_idx] = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------
   // State and registered outputs
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      action_ff          <= action_in;
      addr_ff            <= addr_in;
      stamp_ff           <= stamp_in;
      prev_ff            <= prev_in;
      walk_ff            <= walk_in;
      chk_idx_ff         <= chk_idx_in;
      min_stamp_ff       <= min_stamp_in;
      min_idx_ff         <= min_idx_in;
      mode_ff            <= mode_in;
      rd_live_ff         <= live_ff[ram_rd_idx];
      rsp_front_index_ff <= rsp_front_index_in;
      rsp_back_index_ff  <= rsp_back_index_in;
      rsp_frame_valid_ff <= rsp_frame_valid_in;
      rsp_frame_index_ff <= rsp_frame_index_in;
      rsp_skip_frame_ff  <= rsp_skip_frame_in;
      rsp_last_ff        <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         buf_count_ff  <= CFG_W'(2);
         active_n_ff   <= CNT_W'(2);
         front_ptr_ff  <= '0;
         back_ptr_ff   <= IDX_W'(1);
         front_done_ff <= 1'b0;
         back_done_ff  <= 1'b0;
         live_ff       <= '0;
         valid_ff      <= '0;
         is_front_ff   <= MAX_ENTRIES'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         buf_count_ff  <= buf_count_in;
         active_n_ff   <= active_n_in;
         front_ptr_ff  <= front_ptr_in;
         back_ptr_ff   <= back_ptr_in;
         front_done_ff <= front_done_in;
         back_done_ff  <= back_done_in;
         live_ff       <= live_in;
         valid_ff      <= valid_in;
         is_front_ff   <= is_front_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign csr_ready       = 1'b1;
   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_index = rsp_front_index_ff;
   assign rsp_back_index  = rsp_back_index_ff;
   assign rsp_frame_valid = rsp_frame_valid_ff;
   assign rsp_frame_index = rsp_frame_index_ff;
   assign rsp_skip_frame  = rsp_skip_frame_ff;
   assign rsp_last        = rsp_last_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   a_front_in_chain: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(front_ptr_ff) < active_n_ff)
      else $error("front pointer lies outside the active chain");

   a_back_in_chain: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(back_ptr_ff) < active_n_ff)
      else $error("back pointer lies outside the active chain");

   a_walk_stops_at_front: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (walk_ff != front_ptr_ff))
      else $error("swap walk went past the new front entry");

   a_restart_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ACT_RESTART))
      |=> ((live_ff == '0) && (valid_ff == '0)))
      else $error("restart did not empty the table");

   a_write_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> (state_ff == ST_SCAN))
      else $error("entry memory written outside a scan");
`endif

endmodule

`default_nettype wire

FILE: design/fbsc_entry_ram.sv
// Entry table memory: one write port with per-field enables, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fbsc_entry_ram #(
   parameter  int unsigned DEPTH = 8,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  fbsc_pkg::ram_wr_type   wr,
   input  logic [IDX_W-1:0]       wr_idx,
   input  logic [IDX_W-1:0]       rd_idx,
   output fbsc_pkg::entry_type    rd_data
);
   import fbsc_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         if (wr.origin_en) mem[wr_idx].origin <= wr.data.origin;
         if (wr.image_en)  mem[wr_idx].image  <= wr.data.image;
         if (wr.stamp_en)  mem[wr_idx].stamp  <= wr.data.stamp;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: tb/tb_frame_buffer_swap_chain_tracker.sv
// Self-checking testbench for the frame buffer swap chain tracker.
`timescale 1ns / 1ps

module tb_frame_buffer_swap_chain_tracker;
   import fbsc_pkg::*;

   // The table geometry the block is built with. The predictor uses the same values.
   localparam int unsigned TABLE_DEPTH  = 8;
   localparam int unsigned MATCH_RANGE  = 1024;

   // Image addresses used by the well-formed frame sequences. The stride keeps two
   // images far outside each other's match window.
   localparam logic [31:0] IMAGE_BASE   = 32'h0010_0000;
   localparam logic [31:0] IMAGE_STRIDE = 32'h0002_5800;

   // Cycles allowed after the last result before the block is taken to be idle.
   // This covers the longest scan of a full table plus the swap state.
   localparam int unsigned DRAIN_CYCLES   = 16;
   localparam int unsigned LONG_HOLD      = 200;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   // One result item as it is expected on the result channel.
   typedef struct packed {
      logic [2:0] front_index;
      logic [2:0] back_index;
      logic       frame_valid;
      logic [2:0] frame_index;
      logic       skip_frame;
      logic       last;
   } chain_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_buffer_count = '0;

   logic                req_valid = 1'b0;
   logic                req_ready;
   action_type          req_action = ACT_SET_FRONT;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [STAMP_W-1:0]  req_dlist_count = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [2:0]          rsp_front_index;
   logic [2:0]          rsp_back_index;
   logic                rsp_frame_valid;
   logic [2:0]          rsp_frame_index;
   logic                rsp_skip_frame;
   logic                rsp_last;

   // Predicted copy of the buffer table, pointers and configuration.
   logic [31:0]         fb_origin [TABLE_DEPTH];
   logic [31:0]         fb_image  [TABLE_DEPTH];
   logic [31:0]         fb_stamp  [TABLE_DEPTH];
   logic                fb_valid  [TABLE_DEPTH];
   logic                fb_front  [TABLE_DEPTH];
   logic                front_warmed;
   logic                back_warmed;
   int unsigned         front_sel;
   int unsigned         back_sel;
   int unsigned         chain_len;
   logic [3:0]          buffer_count_reg = 4'd2;

   chain_report_type    pending_reports [$];
   int unsigned         mismatches = 0;
   int unsigned         idle_cycles = 0;
   logic [31:0]         dlist_now = '0;

   // Idling controls. The sender and the receiver each insert short random gaps while
   // their flag is set; a long hold of the receiver is requested by bumping a counter.
   logic                req_gaps = 1'b0;
   logic                rsp_gaps = 1'b0;
   int unsigned         holds_asked = 0;
   int unsigned         holds_done = 0;
   int unsigned         hold_left = 0;
   int unsigned         stall_left = 0;

   frame_buffer_swap_chain_tracker #(
      .MAX_ENTRIES  (TABLE_DEPTH),
      .MATCH_WINDOW (MATCH_RANGE)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_buffer_count (csr_buffer_count),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_address      (req_address),
      .req_dlist_count  (req_dlist_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_front_index  (rsp_front_index),
      .rsp_back_index   (rsp_back_index),
      .rsp_frame_valid  (rsp_frame_valid),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_skip_frame   (rsp_skip_frame),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Predictor of the buffer table.
   // ---------------------------------------------------------------------------------

   // Empties the table and latches the buffer count, clamped to the range 2 to 8.
   // This happens at reset and on a restart item, and at no other time.
   function automatic void clear_table();
      int unsigned k;
      for (k = 0; k < TABLE_DEPTH; k++) begin
         fb_origin[k] = '0;
         fb_image[k]  = '0;
         fb_valid[k]  = 1'b0;
         fb_front[k]  = 1'b0;
         fb_stamp[k]  = '0;
      end
      fb_front[0]  = 1'b1;
      front_sel    = 0;
      back_sel     = 1;
      front_warmed = 1'b0;
      back_warmed  = 1'b0;
      chain_len    = 32'(buffer_count_reg);
      if (chain_len < 2) chain_len = 2;
      if (chain_len > TABLE_DEPTH) chain_len = TABLE_DEPTH;
   endfunction

   // The entry with the oldest stamp. On a tie the lowest index wins, and when no
   // stamp lies below the all-ones value entry 0 is taken.
   function automatic int unsigned oldest_entry(logic skip_front);
      int unsigned k;
      int unsigned pick_idx;
      logic [31:0] lowest;
      pick_idx = 0;
      lowest   = STAMP_NONE;
      for (k = 0; k < chain_len; k++) begin
         if (skip_front && fb_front[k]) continue;
         if (fb_stamp[k] < lowest) begin
            lowest   = fb_stamp[k];
            pick_idx = k;
         end
      end
      return pick_idx;
   endfunction

   function automatic void select_front(logic [31:0] addr);
      int unsigned i;
      logic [31:0] gap;
      // During warm-up the origins are simply filled in order; a repeated origin is
      // ignored. The phase ends once a second origin slot has been reached.
      if (!front_warmed) begin
         for (i = 0; i < chain_len; i++) begin
            if (fb_origin[i] == '0) break;
            if (fb_origin[i] == addr) return;
         end
         if (i < chain_len) fb_origin[i] = addr;
         if (i >= 1) front_warmed = 1'b1;
         return;
      end
      // After warm-up the origin is matched against the colour images, where an
      // origin that equals an image counts as a match.
      for (i = 0; i < chain_len && fb_valid[i]; i++) begin
         gap = (addr >= fb_image[i]) ? addr - fb_image[i] : fb_image[i] - addr;
         if (gap < MATCH_RANGE) begin
            fb_origin[i] = addr;
            front_sel    = i;
            return;
         end
      end
      if (i >= chain_len) i = oldest_entry(1'b0);
      fb_origin[i] = addr;
      front_sel    = i;
   endfunction

   function automatic void select_back(logic [31:0] addr, logic [31:0] stamp);
      int unsigned i;
      logic [31:0] org;
      if (!back_warmed) begin
         for (i = 0; i < chain_len; i++) begin
            org = fb_origin[i];
            if (org == '0) break;
            if (org <= addr && (addr - org) < MATCH_RANGE) begin
               if (fb_image[i] == '0) begin
                  fb_image[i] = addr;
                  fb_valid[i] = 1'b1;
                  fb_stamp[i] = stamp;
               end
               back_sel = i;
               return;
            end
         end
         if (i < chain_len) begin
            fb_image[i] = addr;
            fb_valid[i] = 1'b1;
            fb_stamp[i] = stamp;
            back_sel    = i;
         end
         if (i >= 1) back_warmed = 1'b1;
         return;
      end
      for (i = 0; i < chain_len && fb_valid[i]; i++) begin
         if (fb_image[i] == addr) begin
            fb_stamp[i] = stamp;
            back_sel    = i;
            return;
         end
      end
      // A back buffer skips entries marked as front buffers, but entry 0 is the fallback.
      if (i >= chain_len) i = oldest_entry(1'b1);
      fb_image[i] = addr;
      fb_valid[i] = 1'b1;
      fb_stamp[i] = stamp;
      back_sel    = i;
   endfunction

   // Applies one accepted item to the predicted table and queues the results it gives.
   function automatic void predict_chain_step(action_type act, logic [31:0] addr,
                                              logic [31:0] stamp);
      int unsigned prev;
      int unsigned walked;
      int unsigned total;
      int unsigned k;
      int unsigned walk_idx [8];
      logic        walk_skip [8];
      chain_report_type rep;
      walked = 0;
      case (act)
         ACT_SET_FRONT: select_front(addr);
         ACT_SET_BACK:  select_back(addr, stamp);
         ACT_SWAP: begin
            prev = front_sel;
            // A zero origin register leaves the front selection alone.
            if (addr != '0) select_front(addr);
            // When the selected entry already carries the front mark nothing moves.
            if (!fb_front[front_sel]) begin
               fb_front[prev] = 1'b0;
               while (prev != front_sel && walked < 8) begin
                  prev              = (prev + 1) % chain_len;
                  walk_idx[walked]  = prev;
                  walk_skip[walked] = (prev != front_sel);
                  walked++;
               end
               fb_front[front_sel] = 1'b1;
               back_sel            = (front_sel + 1) % chain_len;
            end
         end
         default: clear_table();
      endcase
      total = (walked > 0) ? walked : 1;
      for (k = 0; k < total; k++) begin
         rep.front_index = 3'(front_sel);
         rep.back_index  = 3'(back_sel);
         rep.frame_valid = (walked > 0);
         rep.frame_index = (walked > 0) ? 3'(walk_idx[k]) : 3'd0;
         rep.skip_frame  = (walked > 0) ? walk_skip[k] : 1'b0;
         rep.last        = (k == total - 1);
         pending_reports.push_back(rep);
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Result checking. Every accepted result item is compared with the oldest
   // expectation; the run carries on after a mismatch.
   // ---------------------------------------------------------------------------------

   function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      chain_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("result item with no expectation waiting");
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            check_field("front_index", want.front_index, rsp_front_index);
            check_field("back_index",  want.back_index,  rsp_back_index);
            check_field("frame_valid", 3'(want.frame_valid), 3'(rsp_frame_valid));
            check_field("frame_index", want.frame_index, rsp_frame_index);
            check_field("skip_frame",  3'(want.skip_frame),  3'(rsp_skip_frame));
            check_field("last",        3'(want.last),        3'(rsp_last));
         end
      end
   end

   // The receiver. A requested long hold takes precedence; otherwise short random
   // stalls are taken while gaps are enabled.
   always @(posedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left  <= LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // The watchdog ends the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------------------

   // Offers one item and waits until it is accepted. Valid is left high on return so
   // that the next item can follow back to back; a gap lowers it first.
   task automatic send_item(action_type act, logic [31:0] addr, logic [31:0] stamp);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_address     <= addr;
      req_dlist_count <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_chain_step(act, addr, stamp);
   endtask

   // Stops offering items, waits for every expected result and lets the block settle.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_buffer_count(logic [3:0] value);
      csr_valid        <= 1'b1;
      csr_buffer_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid        <= 1'b0;
      buffer_count_reg = value;
   endtask

   // Writes a new buffer count while the block is idle and restarts the table, since
   // the count only takes effect on a restart.
   task automatic load_chain_size(logic [3:0] value);
      wait_until_idle();
      write_buffer_count(value);
      send_item(ACT_RESTART, $urandom(), $urandom());
   endtask

   // Random traffic. Most of it is whole frames: a back buffer is rendered, its origin
   // is set and the chain is swapped. The images cycle through a few more slots than
   // the chain holds so that evictions happen. The rest is noise and restarts.
   task automatic run_frames(int unsigned item_budget, int unsigned image_span);
      int unsigned done_items;
      int unsigned pick;
      int unsigned slot;
      int unsigned ring;
      logic [31:0] image;
      logic [31:0] origin;
      done_items = 0;
      ring       = $urandom_range(0, 7);
      while (done_items < item_budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 7) == 0) slot = $urandom_range(0, image_span - 1);
            else slot = ring % image_span;
            ring++;
            image = IMAGE_BASE + slot * IMAGE_STRIDE;
            // The origin lands on the image, inside the window on either side, or
            // exactly on the window edge where it no longer matches.
            case ($urandom_range(0, 5))
               0: origin = image;
               1: origin = image + $urandom_range(1, MATCH_RANGE - 1);
               2: origin = image - $urandom_range(1, MATCH_RANGE - 1);
               3: origin = image + MATCH_RANGE;
               default: origin = image + 32'h280;
            endcase
            dlist_now += $urandom_range(1, 4);
            send_item(ACT_SET_BACK, image, dlist_now);
            send_item(ACT_SET_FRONT, origin, dlist_now);
            send_item(ACT_SWAP, ($urandom_range(0, 5) == 0) ? 32'd0 : origin, dlist_now);
            done_items += 3;
         end else if (pick < 97) begin
            send_item(action_type'(2'($urandom_range(0, 2))),
                      $urandom_range(0, 1) ? $urandom()
                                           : IMAGE_BASE + $urandom_range(0, 20'hFFFFF),
                      $urandom_range(0, 1) ? $urandom() : dlist_now);
            done_items++;
         end else begin
            send_item(ACT_RESTART, $urandom(), $urandom());
            done_items++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------

   // Two buffers: zero and all-ones addresses and stamps, a swap with a zero origin,
   // a swap onto an entry that is already the front, an origin equal to an image and
   // a swap that walks one frame.
   task automatic test_zero_origin_and_extremes();
      write_buffer_count(4'd2);
      send_item(ACT_SWAP,      32'h0000_0000, 32'h0000_0000);
      send_item(ACT_SET_FRONT, 32'h0000_0000, 32'h0000_0000);
      send_item(ACT_SET_FRONT, 32'h0010_0200, 32'h0000_0000);
      send_item(ACT_SET_FRONT, 32'h0012_0000, 32'h0000_0000);
      send_item(ACT_SET_BACK,  32'h0010_0300, 32'h0000_0000);
      send_item(ACT_SET_BACK,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_SET_FRONT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_SWAP,      32'h0010_0300, 32'h0000_0001);
      send_item(ACT_SWAP,      32'hFFFF_FFFF, 32'h0000_0002);
      send_item(ACT_RESTART,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Four buffers: the edges of the match window, a tie between equal stamps on
   // eviction, a multi-frame walk with skipped frames, and eviction when every stamp
   // is all ones.
   task automatic test_window_and_eviction();
      load_chain_size(4'd4);
      send_item(ACT_SET_FRONT, 32'h0020_0000, 32'd1);
      send_item(ACT_SET_FRONT, 32'h0021_0000, 32'd1);
      send_item(ACT_SET_BACK,  32'h0020_0100, 32'd5);
      send_item(ACT_SET_BACK,  32'h0021_03FF, 32'd5);
      send_item(ACT_SET_BACK,  32'h0022_0400, 32'd5);
      send_item(ACT_SET_BACK,  32'h0023_0000, 32'd5);
      send_item(ACT_SET_BACK,  32'h0024_0000, 32'd6);
      send_item(ACT_SET_FRONT, 32'h0022_0000, 32'd7);
      send_item(ACT_SWAP,      32'h0023_0010, 32'd8);
      send_item(ACT_SWAP,      32'h0020_0100, 32'd9);
      send_item(ACT_SWAP,      32'h0000_0000, 32'd9);
      send_item(ACT_SET_BACK,  32'h0020_0100, 32'hFFFF_FFFF);
      send_item(ACT_SET_BACK,  32'h0024_0000, 32'hFFFF_FFFF);
      send_item(ACT_SET_BACK,  32'h0022_0400, 32'hFFFF_FFFF);
      send_item(ACT_SET_BACK,  32'h0023_0000, 32'hFFFF_FFFF);
      send_item(ACT_SET_FRONT, 32'h0100_0000, 32'hFFFF_FFFF);
   endtask

   // A count below the range is clamped up to two buffers.
   task automatic test_count_below_range();
      load_chain_size(4'd0);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      run_frames(25, 4);
   endtask

   // A count above the range is clamped down to eight buffers.
   task automatic test_count_above_range();
      load_chain_size(4'd15);
      run_frames(30, 10);
   endtask

   task automatic test_full_chain();
      load_chain_size(4'd8);
      req_gaps = 1'b0;
      run_frames(25, 10);
   endtask

   // The receiver holds off for a long stretch while items keep being offered, so
   // the block fills up and stops taking input.
   task automatic test_result_backpressure();
      load_chain_size(4'd5);
      req_gaps = 1'b1;
      holds_asked++;
      run_frames(25, 7);
   endtask

   // The closing stretch runs with no idling on either side.
   task automatic test_steady_stream();
      load_chain_size(4'd3);
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      run_frames(25, 5);
   endtask

   initial begin
      clear_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_origin_and_extremes();
      test_window_and_eviction();
      test_count_below_range();
      test_count_above_range();
      test_full_chain();
      test_result_backpressure();
      test_steady_stream();

      wait_until_idle();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
